// ----- design/ssd_pkg.sv -----
`default_nettype none
package ssd_pkg;

  // Request type codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SHOW = 1'b1;

  // Largest value the display can show
  localparam int unsigned MaxShown = 9999;

  // Reciprocal constants for division by 1000, 100 and 10 (exact for 0..9999)
  localparam int unsigned Recip1000 = 16778;  // 2^24 / 1000, rounded up
  localparam int unsigned Recip100  = 10486;  // 2^20 / 100, rounded up
  localparam int unsigned Recip10   = 13108;  // 2^17 / 10, rounded up

  // Command queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Bus command bytes
  localparam logic [7:0] CMD_DATA = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  typedef struct packed {
    logic        req_type;
    logic [15:0] number;
  } req_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_drive;
    logic busy_res;
    logic accepted;
  } res_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic            show;
    logic [3:0][7:0] codes;
  } cmd_t;

  function automatic logic [7:0] seg_encode(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

// ----- design/ssd_front.sv -----
`default_nettype none
module ssd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  ssd_pkg::req_t      req_i,
  output logic               full_o,
  output logic               cmd_valid_o,
  output ssd_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_full_i
);
  import ssd_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  logic        s1_show_q;
  logic [13:0] s1_num_q;
  logic [3:0]  s1_q1000_q;
  logic [6:0]  s1_q100_q;
  logic [9:0]  s1_q10_q;

  logic        s2_valid_q, s2_valid_d;
  cmd_t        s2_cmd_q, s2_cmd_d;

  logic        s1_ready, s2_ready, s1_load, s2_load;
  logic [13:0] num_clamp;
  logic [28:0] prod1000, prod100, prod10;
  logic [3:0]  d0, d1, d2, d3;
  logic [13:0] rem3;
  logic [9:0]  rem2;
  logic [6:0]  rem1;
  logic        blank0, blank1, blank2;

  // Stall control: each stage moves when the one after it has room
  assign s2_ready = !s2_valid_q || !cmd_full_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s1_load  = push_i && s1_ready;
  assign s2_load  = s1_valid_q && s2_ready;
  assign full_o   = !s1_ready;

  // Clamp and divide by reciprocal multiplication
  always_comb begin
    num_clamp = (req_i.number > 16'(MaxShown)) ? 14'(MaxShown) : req_i.number[13:0];
    prod1000  = 29'(num_clamp) * 29'(Recip1000);
    prod100   = 29'(num_clamp) * 29'(Recip100);
    prod10    = 29'(num_clamp) * 29'(Recip10);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  assign s1_valid_d = s1_load || (s1_valid_q && !s2_ready);

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_show_q  <= (req_i.req_type == REQ_SHOW);
      s1_num_q   <= num_clamp;
      s1_q1000_q <= prod1000[27:24];
      s1_q100_q  <= prod100[26:20];
      s1_q10_q   <= prod10[26:17];
    end
  end

  // Recover digits, blank leading zeros, map to segments
  always_comb begin
    rem3   = s1_num_q - 14'(s1_q10_q) * 14'd10;
    rem2   = s1_q10_q - 10'(s1_q100_q) * 10'd10;
    rem1   = s1_q100_q - 7'(s1_q1000_q) * 7'd10;
    d0     = s1_q1000_q;
    d1     = rem1[3:0];
    d2     = rem2[3:0];
    d3     = rem3[3:0];
    blank0 = (d0 == 4'd0);
    blank1 = blank0 && (d1 == 4'd0);
    blank2 = blank1 && (d2 == 4'd0);
    s2_cmd_d.show     = s1_show_q;
    s2_cmd_d.codes[0] = blank0 ? SEG_BLANK : seg_encode(d0);
    s2_cmd_d.codes[1] = blank1 ? SEG_BLANK : seg_encode(d1);
    s2_cmd_d.codes[2] = blank2 ? SEG_BLANK : seg_encode(d2);
    s2_cmd_d.codes[3] = seg_encode(d3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  assign s2_valid_d = s2_load || (s2_valid_q && cmd_full_i);

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_cmd_q <= s2_cmd_d;
    end
  end

  assign cmd_valid_o = s2_valid_q;
  assign cmd_o       = s2_cmd_q;

endmodule
`default_nettype wire

// ----- design/ssd_queue.sv -----
`default_nettype none
module ssd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  ssd_pkg::cmd_t      wr_data_i,
  output logic               full_o,
  input  wire logic          rd_en_i,
  output ssd_pkg::cmd_t      rd_data_o,
  output logic               empty_o
);
  import ssd_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign wr      = wr_en_i && !full_o;
  assign rd      = rd_en_i && !empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wptr_d = wr ? QPtrW'(wptr_q + 1'b1) : wptr_q;
    rptr_d = rd ? QPtrW'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q;
    if (wr && !rd) begin
      cnt_d = QCntW'(cnt_q + 1'b1);
    end else if (rd && !wr) begin
      cnt_d = QCntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rptr_q];

  property p_cnt_bounded;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCntW'(QDepth);
  endproperty
  a_cnt_bounded: assert property (p_cnt_bounded) else $error("queue count overflow");

  property p_ptr_gap;
    @(posedge clk_i) disable iff (!rst_ni)
      (cnt_q != QCntW'(QDepth)) |-> (QPtrW'(wptr_q - rptr_q) == cnt_q[QPtrW-1:0]);
  endproperty
  a_ptr_gap: assert property (p_ptr_gap) else $error("queue pointers disagree with count");

  property p_full_blocks_write;
    @(posedge clk_i) disable iff (!rst_ni) (full_o && !rd) |=> $stable(wptr_q);
  endproperty
  a_full_blocks_write: assert property (p_full_blocks_write)
    else $error("write taken while full");

endmodule
`default_nettype wire

// ----- design/ssd_back.sv -----
`default_nettype none
module ssd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_empty_i,
  input  ssd_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  wire logic          pop,
  output ssd_pkg::res_t      res_o
);
  import ssd_pkg::*;

  localparam logic [6:0] LastPhase = 7'd116;

  logic            active_q, active_d;
  logic [6:0]      phase_q, phase_d;
  logic [3:0][7:0] seg_q, seg_d;
  logic            clk_q, clk_d;
  logic            dio_q, dio_d;
  logic            drv_q, drv_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;

  logic            take;
  logic            in_byte;
  logic [7:0]      byte_val;
  logic [4:0]      slot;
  logic [6:0]      seg_off;
  logic [1:0]      seg_idx;
  logic            t_clk, t_dio, t_drv;

  // Take the next transaction when the result register is free or draining
  assign take      = !cmd_empty_i && (!res_valid_q || pop);
  assign cmd_pop_o = take;
  assign empty     = !res_valid_q;

  // Decode the bus pins for the current phase
  always_comb begin
    t_clk    = 1'b1;
    t_dio    = 1'b1;
    t_drv    = 1'b1;
    in_byte  = 1'b0;
    byte_val = CMD_DATA;
    slot     = '0;
    seg_idx  = '0;
    seg_off  = phase_q - 7'd42;
    if (phase_q < 7'd2 || (phase_q >= 7'd22 && phase_q < 7'd24)) begin
      t_dio = ~phase_q[0];
    end else if ((phase_q >= 7'd20 && phase_q < 7'd22) ||
                 (phase_q >= 7'd114 && phase_q < 7'd116)) begin
      t_clk = phase_q[0];
      t_dio = 1'b0;
    end else if (phase_q >= 7'd2 && phase_q < 7'd20) begin
      in_byte  = 1'b1;
      byte_val = CMD_DATA;
      slot     = 5'(phase_q - 7'd2);
    end else if (phase_q >= 7'd24 && phase_q < 7'd42) begin
      in_byte  = 1'b1;
      byte_val = CMD_ADDR;
      slot     = 5'(phase_q - 7'd24);
    end else if (phase_q >= 7'd42 && phase_q < 7'd114) begin
      in_byte = 1'b1;
      if (seg_off < 7'd18) begin
        seg_idx = 2'd0;
        slot    = 5'(seg_off);
      end else if (seg_off < 7'd36) begin
        seg_idx = 2'd1;
        slot    = 5'(seg_off - 7'd18);
      end else if (seg_off < 7'd54) begin
        seg_idx = 2'd2;
        slot    = 5'(seg_off - 7'd36);
      end else begin
        seg_idx = 2'd3;
        slot    = 5'(seg_off - 7'd54);
      end
      byte_val = seg_q[seg_idx];
    end
    if (in_byte) begin
      t_clk = slot[0];
      if (slot < 5'd16) begin
        t_dio = byte_val[slot[3:1]];
      end else begin
        t_dio = dio_q;
        t_drv = 1'b0;
      end
    end
  end

  // Update frame state and build the result
  always_comb begin
    active_d = active_q;
    phase_d  = phase_q;
    seg_d    = seg_q;
    clk_d    = clk_q;
    dio_d    = dio_q;
    drv_d    = drv_q;
    res_d    = res_q;
    res_d.accepted = 1'b0;
    if (take) begin
      if (cmd_i.show) begin
        if (!active_q) begin
          seg_d          = cmd_i.codes;
          phase_d        = '0;
          active_d       = 1'b1;
          res_d.accepted = 1'b1;
        end
      end else if (active_q) begin
        clk_d = t_clk;
        dio_d = t_dio;
        drv_d = t_drv;
        if (phase_q >= LastPhase) begin
          active_d = 1'b0;
          phase_d  = '0;
        end else begin
          phase_d = 7'(phase_q + 1'b1);
        end
      end
      res_d.clk_level = clk_d;
      res_d.dio_level = drv_d & dio_d;
      res_d.dio_drive = drv_d;
      res_d.busy_res  = active_d;
    end
  end

  assign res_valid_d = take || (res_valid_q && !pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      phase_q     <= '0;
      seg_q       <= '0;
      clk_q       <= 1'b1;
      dio_q       <= 1'b1;
      drv_q       <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      phase_q     <= phase_d;
      seg_q       <= seg_d;
      clk_q       <= clk_d;
      dio_q       <= dio_d;
      drv_q       <= drv_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  property p_idle_phase;
    @(posedge clk_i) disable iff (!rst_ni) !active_q |-> (phase_q == '0);
  endproperty
  a_idle_phase: assert property (p_idle_phase) else $error("phase moved while idle");

  property p_idle_bus;
    @(posedge clk_i) disable iff (!rst_ni) !active_q |-> (clk_q && dio_q && drv_q);
  endproperty
  a_idle_bus: assert property (p_idle_bus) else $error("bus not idle between frames");

  property p_phase_range;
    @(posedge clk_i) disable iff (!rst_ni) active_q |-> (phase_q <= LastPhase);
  endproperty
  a_phase_range: assert property (p_phase_range) else $error("phase beyond frame end");

  property p_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      (take && cmd_i.show && !active_q) |=> (active_q && res_q.accepted && res_q.busy_res);
  endproperty
  a_accept_busy: assert property (p_accept_busy) else $error("show not started");

endmodule
`default_nettype wire

// ----- design/seven_segment_serial_display_driver_core.sv -----
// Four-digit seven-segment driver for a two-wire clock/data display bus.
//
// Input channel (push/full): one transaction per request. A show request
// latches a number (saturated to 9999), converts it to segment codes with
// leading zeros blanked and starts a 117-tick frame. A tick request advances
// the bus by one half-bit phase. Show requests during a frame are dropped.
// Result channel (empty/pop): exactly one result per input transaction, in
// order, with the pin levels after that transaction and busy/accept flags.
//
// Throughput: one transaction per cycle on both sides while the receiver
// keeps popping. From push to result the path is registered in the first
// front stage (clamp and reciprocal multiply), then the second front stage
// (digit recovery and segment lookup), the command queue and the back-end
// result register, in that order.
// A four-entry command queue decouples the front stages from the bus
// sequencer; when the receiver stops popping, the result register holds,
// the queue fills and full rises after the front stages back up.
// Reset puts the bus idle (clock high, data high and driven), clears the
// frame state, segment codes and all queues.
`default_nettype none
module seven_segment_serial_display_driver_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  ssd_pkg::req_t      req_i,
  output logic               empty,
  input  wire logic          pop,
  output ssd_pkg::res_t      res_o
);
  import ssd_pkg::*;

  logic cmd_valid, q_full, q_empty, q_pop;
  cmd_t cmd_front, cmd_back;

  ssd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_front),
    .cmd_full_i  (q_full)
  );

  ssd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_valid),
    .wr_data_i (cmd_front),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .rd_data_o (cmd_back),
    .empty_o   (q_empty)
  );

  ssd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_i       (cmd_back),
    .cmd_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire
